[sv/mbe_pkg.sv]
// Shared types and state codes for the Mandelbrot escape-time unit.
`timescale 1ns / 1ps

package mbe_pkg;

	// One request: the point c in signed fixed point.
	typedef struct packed {
		logic signed [31:0] point_real;
		logic signed [31:0] point_imag;
	} point_t;

	// One result: inside flag, escape count and final squared magnitude in Q32.32.
	typedef struct packed {
		logic        inside_res;
		logic [15:0] escape_count;
		logic [63:0] final_magnitude_sq;
	} result_t;

	// Request to the shared multiplier.
	typedef struct packed {
		logic go;
		logic half;   // shift by one fraction bit less, giving 2*a*b
	} mul_req_t;

	// Response of the shared multiplier.
	typedef struct packed {
		logic               done;
		logic signed [63:0] value;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_Y2,
		ST_Y2_W,
		ST_A2,
		ST_A2_W,
		ST_Q,
		ST_S,
		ST_LHS,
		ST_LHS_W,
		ST_CMP1,
		ST_B2,
		ST_B2_W,
		ST_BSUM,
		ST_SX,
		ST_SX_W,
		ST_SY,
		ST_SY_W,
		ST_CHK,
		ST_XY,
		ST_XY_W,
		ST_NX,
		ST_NY
	} mbe_state_t;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

endpackage

[sv/mbe_mul.sv]
// Multi-cycle saturating fixed-point multiplier built on one 32x32 multiplier.
`timescale 1ns / 1ps

module mbe_mul #(
	parameter int FRAC_BITS = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbe_pkg::mul_req_t   req,
	input  logic signed [63:0]  op_a,
	input  logic signed [63:0]  op_b,
	output mbe_pkg::mul_rsp_t   rsp
);

	localparam logic [127:0] MASK_F  = (128'd1 << FRAC_BITS) - 128'd1;
	localparam logic [127:0] MASK_F1 = (128'd1 << (FRAC_BITS - 1)) - 128'd1;

	logic         run_q;
	logic [2:0]   phase_q;
	logic         done_q;
	logic [63:0]  am_q;
	logic [63:0]  bm_q;
	logic         neg_q;
	logic         half_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [63:0]  qlo_q;
	logic         qhi_q;
	logic         rem_q;
	logic signed [63:0] val_q;

	logic [31:0]  mx;
	logic [31:0]  my;
	logic [63:0]  prod;
	logic [127:0] pp_sh;
	logic [127:0] acc_shift;
	logic         acc_rem;
	logic [64:0]  q_inc;
	logic signed [63:0] val_d;

	// Partial product order: low*low, low*high, high*low, high*high.
	always_comb begin
		case (phase_q)
			3'd0: begin
				mx = am_q[31:0];
				my = bm_q[31:0];
			end
			3'd1: begin
				mx = am_q[31:0];
				my = bm_q[63:32];
			end
			3'd2: begin
				mx = am_q[63:32];
				my = bm_q[31:0];
			end
			default: begin
				mx = am_q[63:32];
				my = bm_q[63:32];
			end
		endcase
		prod = {32'd0, mx} * {32'd0, my};

		// The product registered in the previous phase lands at its own weight.
		case (phase_q)
			3'd1:         pp_sh = {64'd0, pp_q};
			3'd2, 3'd3:   pp_sh = {32'd0, pp_q, 32'd0};
			default:      pp_sh = {pp_q, 64'd0};
		endcase

		acc_shift = half_q ? (acc_q >> (FRAC_BITS - 1)) : (acc_q >> FRAC_BITS);
		acc_rem   = half_q ? (|(acc_q & MASK_F1)) : (|(acc_q & MASK_F));

		// Negative results round toward minus infinity: bump the magnitude on a remainder.
		q_inc = {1'b0, qlo_q} + {64'd0, rem_q};
		if (!neg_q) begin
			val_d = (qhi_q || qlo_q[63]) ? mbe_pkg::S64_MAX : $signed(qlo_q);
		end else if (qhi_q || q_inc[64] || q_inc[63]) begin
			val_d = mbe_pkg::S64_MIN;
		end else begin
			val_d = $signed(~q_inc[63:0] + 64'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q   <= 1'b1;
				phase_q <= 3'd0;
			end else if (run_q) begin
				if (phase_q == 3'd6) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				phase_q <= phase_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			am_q   <= op_a[63] ? (~op_a + 64'd1) : op_a;
			bm_q   <= op_b[63] ? (~op_b + 64'd1) : op_b;
			neg_q  <= op_a[63] ^ op_b[63];
			half_q <= req.half;
			acc_q  <= '0;
		end else if (run_q) begin
			if (phase_q <= 3'd3) begin
				pp_q <= prod;
			end
			if (phase_q >= 3'd1 && phase_q <= 3'd4) begin
				acc_q <= acc_q + pp_sh;
			end
			if (phase_q == 3'd5) begin
				qlo_q <= acc_shift[63:0];
				qhi_q <= |acc_shift[127:64];
				rem_q <= acc_rem;
			end
			if (phase_q == 3'd6) begin
				val_q <= val_d;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = val_q;

endmodule

[sv/mandelbrot_escape_iteration_unit.sv]
// Top level of the Mandelbrot escape-time unit: sequencer, shared adder and register file.
`timescale 1ns / 1ps

// Usage:
// A request is taken on a rising edge with start high and busy low; point carries c.
// busy stays high until the request is finished; then done pulses for one cycle with
// result valid in that same cycle. The receiver cannot stall, so done is never held.
// cfg_we/cfg_data write the iteration limit (reset value 256); write it only while idle.
// All arithmetic runs on one shared 32x32 multiplier, which forms each 64-bit fixed-point
// product, and one shared 64-bit saturating adder.
// Points in the main cardioid or the period-2 bulb finish without iterating; any other
// point runs rounds of z = z*z + c, each costing three products, until it escapes or
// reaches the limit, and an escaped point runs two more rounds before done.
// A new request is taken on the cycle in which done is high.
// Reset clears the sequencer to idle, drops done and restores the limit to 256.
module mandelbrot_escape_iteration_unit #(
	parameter int COORD_FRAC_BITS = 28,
	parameter int COUNT_WIDTH     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mbe_pkg::point_t     point,
	output logic                done,
	output mbe_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	localparam int F = COORD_FRAC_BITS;
	localparam logic signed [63:0] QUARTER   = 64'sd1 << (F - 2);
	localparam logic signed [63:0] ONE       = 64'sd1 << F;
	localparam logic signed [63:0] SIXTEENTH = 64'sd1 << (F - 4);
	localparam logic [63:0]        FOUR      = 64'd4 << F;
	localparam logic [32:0]        CNT_MAX   = (33'd1 << COUNT_WIDTH) - 33'd1;
	localparam int SH_UP = (F < 32) ? (32 - F) : 0;
	localparam int SH_DN = (F >= 32) ? (F - 32) : 0;

	mbe_pkg::mbe_state_t state_q, state_d;
	logic               done_q;
	logic [15:0]        max_iter_q;
	mbe_pkg::result_t   result_q;

	logic signed [63:0] cx_q, cy_q, zx_q, zy_q;
	logic signed [63:0] y2_q, a_q, q_q, t_q, sy_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic               esc_q;
	logic [1:0]         rounds_q;

	mbe_pkg::mul_req_t  mul_req;
	mbe_pkg::mul_rsp_t  mul_rsp;
	logic signed [63:0] mul_a, mul_b;

	logic [63:0]        add_a, add_b, add_bx;
	logic               add_sub;
	logic [64:0]        add_sum;
	logic signed [63:0] add_sat;
	logic [63:0]        add_raw;

	logic [32:0]        lim33;
	logic [32:0]        cnt33;
	logic               cnt_below;
	logic [127:0]       mag_up;
	logic [63:0]        mag_q32;
	logic [31:0]        cnt32;

	logic               emit;
	mbe_pkg::result_t   result_d;

	mbe_mul #(
		.FRAC_BITS (COORD_FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.rsp    (mul_rsp)
	);

	// Shared saturating adder; the raw sum serves the unsigned magnitude.
	always_comb begin
		add_bx  = add_sub ? ~add_b : add_b;
		add_sum = {add_a[63], add_a} + {add_bx[63], add_bx} + {64'd0, add_sub};
		add_raw = add_sum[63:0];
		if (add_sum[64] != add_sum[63]) begin
			add_sat = add_sum[64] ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
		end else begin
			add_sat = $signed(add_sum[63:0]);
		end
	end

	always_comb begin
		lim33     = ({17'd0, max_iter_q} > CNT_MAX) ? CNT_MAX : {17'd0, max_iter_q};
		cnt33     = 33'(cnt_q);
		cnt_below = cnt33 < lim33;
		cnt32     = 32'(cnt_q);

		mag_up = {64'd0, add_raw} << SH_UP;
		if (F < 32) begin
			mag_q32 = (|mag_up[127:64]) ? '1 : mag_up[63:0];
		end else begin
			mag_q32 = add_raw >> SH_DN;
		end
	end

	always_comb begin
		state_d  = state_q;
		mul_req  = '0;
		mul_a    = zx_q;
		mul_b    = zx_q;
		add_a    = t_q;
		add_b    = y2_q;
		add_sub  = 1'b0;
		emit     = 1'b0;
		result_d = '0;
		result_d.inside_res = 1'b1;

		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mbe_pkg::ST_Y2;
				end
			end
			mbe_pkg::ST_Y2: begin
				mul_req.go = 1'b1;
				mul_a      = cy_q;
				mul_b      = cy_q;
				add_a      = cx_q;
				add_b      = QUARTER;
				add_sub    = 1'b1;
				state_d    = mbe_pkg::ST_Y2_W;
			end
			mbe_pkg::ST_Y2_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_A2;
				end
			end
			mbe_pkg::ST_A2: begin
				mul_req.go = 1'b1;
				mul_a      = a_q;
				mul_b      = a_q;
				state_d    = mbe_pkg::ST_A2_W;
			end
			mbe_pkg::ST_A2_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_Q;
				end
			end
			mbe_pkg::ST_Q: begin
				state_d = mbe_pkg::ST_S;
			end
			mbe_pkg::ST_S: begin
				add_a   = q_q;
				add_b   = a_q;
				state_d = mbe_pkg::ST_LHS;
			end
			mbe_pkg::ST_LHS: begin
				mul_req.go = 1'b1;
				mul_a      = q_q;
				mul_b      = t_q;
				state_d    = mbe_pkg::ST_LHS_W;
			end
			mbe_pkg::ST_LHS_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_CMP1;
				end
			end
			mbe_pkg::ST_CMP1: begin
				add_a = cx_q;
				add_b = ONE;
				if (t_q < (y2_q >>> 2)) begin
					emit    = 1'b1;
					state_d = mbe_pkg::ST_IDLE;
				end else begin
					state_d = mbe_pkg::ST_B2;
				end
			end
			mbe_pkg::ST_B2: begin
				mul_req.go = 1'b1;
				mul_a      = a_q;
				mul_b      = a_q;
				state_d    = mbe_pkg::ST_B2_W;
			end
			mbe_pkg::ST_B2_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_BSUM;
				end
			end
			mbe_pkg::ST_BSUM: begin
				if (add_sat < SIXTEENTH) begin
					emit    = 1'b1;
					state_d = mbe_pkg::ST_IDLE;
				end else begin
					state_d = mbe_pkg::ST_SX;
				end
			end
			mbe_pkg::ST_SX: begin
				mul_req.go = 1'b1;
				state_d    = mbe_pkg::ST_SX_W;
			end
			mbe_pkg::ST_SX_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_SY;
				end
			end
			mbe_pkg::ST_SY: begin
				mul_req.go = 1'b1;
				mul_a      = zy_q;
				mul_b      = zy_q;
				state_d    = mbe_pkg::ST_SY_W;
			end
			mbe_pkg::ST_SY_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_CHK;
				end
			end
			mbe_pkg::ST_CHK: begin
				// Both squares are nonnegative, so the raw sum is the exact |z|^2.
				add_b = sy_q;
				if (!esc_q) begin
					if (add_raw < FOUR && cnt_below) begin
						state_d = mbe_pkg::ST_XY;
					end else if (!cnt_below) begin
						emit    = 1'b1;
						state_d = mbe_pkg::ST_IDLE;
					end else begin
						state_d = mbe_pkg::ST_XY;
					end
				end else if (rounds_q == 2'd0) begin
					emit     = 1'b1;
					result_d.inside_res         = 1'b0;
					result_d.escape_count       = cnt32[15:0];
					result_d.final_magnitude_sq = mag_q32;
					state_d  = mbe_pkg::ST_IDLE;
				end else begin
					state_d = mbe_pkg::ST_XY;
				end
			end
			mbe_pkg::ST_XY: begin
				mul_req.go   = 1'b1;
				mul_req.half = 1'b1;
				mul_a        = zx_q;
				mul_b        = zy_q;
				add_b        = sy_q;
				add_sub      = 1'b1;
				state_d      = mbe_pkg::ST_XY_W;
			end
			mbe_pkg::ST_XY_W: begin
				if (mul_rsp.done) begin
					state_d = mbe_pkg::ST_NX;
				end
			end
			mbe_pkg::ST_NX: begin
				add_b   = cx_q;
				state_d = mbe_pkg::ST_NY;
			end
			mbe_pkg::ST_NY: begin
				add_a   = sy_q;
				add_b   = cy_q;
				state_d = mbe_pkg::ST_SX;
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mbe_pkg::ST_IDLE;
			done_q     <= 1'b0;
			max_iter_q <= 16'd256;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_we) begin
				max_iter_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result_d;
		end
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				cx_q <= {{32{point.point_real[31]}}, point.point_real};
				cy_q <= {{32{point.point_imag[31]}}, point.point_imag};
			end
			mbe_pkg::ST_Y2: begin
				a_q <= add_sat;
			end
			mbe_pkg::ST_Y2_W: begin
				y2_q <= mul_rsp.value;
			end
			mbe_pkg::ST_A2_W, mbe_pkg::ST_LHS_W, mbe_pkg::ST_B2_W, mbe_pkg::ST_SX_W: begin
				t_q <= mul_rsp.value;
			end
			mbe_pkg::ST_Q: begin
				q_q <= add_sat;
			end
			mbe_pkg::ST_S: begin
				t_q <= add_sat;
			end
			mbe_pkg::ST_CMP1: begin
				a_q <= add_sat;
			end
			mbe_pkg::ST_BSUM: begin
				zx_q     <= '0;
				zy_q     <= '0;
				cnt_q    <= COUNT_WIDTH'(1);
				esc_q    <= 1'b0;
				rounds_q <= 2'd0;
			end
			mbe_pkg::ST_SY_W, mbe_pkg::ST_XY_W: begin
				sy_q <= mul_rsp.value;
			end
			mbe_pkg::ST_CHK: begin
				// Leaving the loop below the limit means escape: two more rounds follow.
				if (!esc_q && !(add_raw < FOUR && cnt_below) && cnt_below) begin
					esc_q    <= 1'b1;
					rounds_q <= 2'd2;
				end
			end
			mbe_pkg::ST_XY: begin
				t_q <= add_sat;
			end
			mbe_pkg::ST_NX: begin
				zx_q <= add_sat;
			end
			mbe_pkg::ST_NY: begin
				zy_q <= add_sat;
				if (esc_q) begin
					rounds_q <= rounds_q - 2'd1;
				end else begin
					cnt_q <= cnt_q + COUNT_WIDTH'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != mbe_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[bench/mandelbrot_escape_iteration_unit_tb.sv]
// Self-checking testbench for the Mandelbrot escape-time unit with a bit-exact predictor.
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_unit_tb;

	localparam int FRAC = 28;
	localparam int ROUND_CAP = 70;
	localparam int DRAIN_GAP = 60;
	localparam longint CYCLE_LIMIT = 6000000;

	localparam logic signed [63:0] FX_ONE       = 64'sh0000_0000_1000_0000;
	localparam logic signed [63:0] FX_QUARTER   = 64'sh0000_0000_0400_0000;
	localparam logic signed [63:0] FX_SIXTEENTH = 64'sh0000_0000_0100_0000;
	localparam logic [63:0]        FX_FOUR      = 64'h0000_0000_4000_0000;

	typedef struct packed {
		mbe_pkg::result_t res;
		logic [31:0]      rounds;
	} escape_prediction_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	mbe_pkg::point_t  point_in = '0;
	logic        done;
	mbe_pkg::result_t result;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;

	mbe_pkg::point_t  points_to_send[$];
	mbe_pkg::result_t expected_results[$];
	int      sender_idle_pct = 11;
	logic [15:0] limit_now = 16'd256;
	int      mismatches = 0;
	longint  cycle_count = 0;

	mandelbrot_escape_iteration_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.point    (point_in),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// floor(a*b / 2^sh) on the exact 128-bit product, saturated to 64 bits.
	function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic [63:0]  ma, mb;
		logic [127:0] p, q;
		logic         rem;
		ma = a[63] ? 64'd0 - a : a;
		mb = b[63] ? 64'd0 - b : b;
		p = {64'd0, ma} * {64'd0, mb};
		q = p >> sh;
		rem = |(p & ((128'd1 << sh) - 128'd1));
		if (a[63] == b[63])
			return (q[127:63] != 0) ? mbe_pkg::S64_MAX : q[63:0];
		q = q + {127'd0, rem};
		if (q[127:63] != 0)
			return mbe_pkg::S64_MIN;
		return 64'd0 - q[63:0];
	endfunction

	function automatic logic signed [63:0] fx_square(input logic signed [63:0] a);
		return fx_product(a, a, FRAC);
	endfunction

	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_diff(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? mbe_pkg::S64_MIN : mbe_pkg::S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] magnitude_sq(input logic signed [63:0] zx,
			input logic signed [63:0] zy);
		logic [63:0] sx, sy;
		sx = fx_square(zx);
		sy = fx_square(zy);
		return sx + sy;
	endfunction

	// One round z = z*z + c; returns {new real, new imaginary}.
	function automatic logic [127:0] next_z(input logic signed [63:0] zx,
			input logic signed [63:0] zy, input logic signed [63:0] cx,
			input logic signed [63:0] cy);
		logic signed [63:0] nx, ny;
		nx = sat_sum(sat_diff(fx_square(zx), fx_square(zy)), cx);
		ny = sat_sum(fx_product(zx, zy, FRAC - 1), cy);
		return {nx, ny};
	endfunction

	// Escape-time result of one point. The search gives up once more than cap rounds
	// would be needed, which the random stimulus uses to keep runs short.
	function automatic escape_prediction_t escape_time_of(input mbe_pkg::point_t pt,
			input logic [15:0] lim, input int cap);
		escape_prediction_t pr;
		logic signed [63:0] cx, cy, zx, zy, y2, a, q, lhs, b;
		logic [63:0]        m;
		int                 k;
		pr = '0;
		pr.res.inside_res = 1'b1;
		cx = {{32{pt.point_real[31]}}, pt.point_real};
		cy = {{32{pt.point_imag[31]}}, pt.point_imag};
		y2 = fx_square(cy);
		a = sat_diff(cx, FX_QUARTER);
		q = sat_sum(fx_square(a), y2);
		lhs = fx_product(q, sat_sum(q, a), FRAC);
		if (lhs < (y2 >>> 2))
			return pr;
		b = sat_sum(cx, FX_ONE);
		if (sat_sum(fx_square(b), y2) < FX_SIXTEENTH)
			return pr;
		zx = '0;
		zy = '0;
		k = 1;
		while (magnitude_sq(zx, zy) < FX_FOUR && k < int'(lim)) begin
			if (k > cap) begin
				pr.rounds = k;
				return pr;
			end
			{zx, zy} = next_z(zx, zy, cx, cy);
			k++;
		end
		if (k >= int'(lim)) begin
			pr.rounds = k - 1;
			return pr;
		end
		{zx, zy} = next_z(zx, zy, cx, cy);
		{zx, zy} = next_z(zx, zy, cx, cy);
		m = magnitude_sq(zx, zy);
		pr.res.inside_res = 1'b0;
		pr.res.escape_count = k[15:0];
		pr.res.final_magnitude_sq = (m > 64'h0FFF_FFFF_FFFF_FFFF) ? '1 : (m << 4);
		pr.rounds = k + 1;
		return pr;
	endfunction

	// Mostly points around the set, some raw 32-bit noise and some extreme coordinates.
	function automatic mbe_pkg::point_t random_point();
		mbe_pkg::point_t pt;
		int     sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			pt.point_real = int'($urandom_range(805306368)) - 603979776;
			pt.point_imag = int'($urandom_range(805306368)) - 402653184;
		end else if (sel < 85) begin
			pt.point_real = $urandom;
			pt.point_imag = $urandom;
		end else begin
			pt.point_real = $urandom;
			pt.point_imag = $urandom;
			case ($urandom_range(4))
				0: pt.point_real = 32'h8000_0000;
				1: pt.point_real = 32'h7FFF_FFFF;
				2: pt.point_real = 32'h0000_0000;
				3: pt.point_real = 32'hFFFF_FFFF;
				default: ;
			endcase
			case ($urandom_range(4))
				0: pt.point_imag = 32'h8000_0000;
				1: pt.point_imag = 32'h7FFF_FFFF;
				2: pt.point_imag = 32'h0000_0000;
				3: pt.point_imag = 32'h0000_0001;
				default: ;
			endcase
		end
		return pt;
	endfunction

	task automatic queue_point(input logic [31:0] re, input logic [31:0] im);
		mbe_pkg::point_t    pt;
		escape_prediction_t pr;
		pt.point_real = re;
		pt.point_imag = im;
		pr = escape_time_of(pt, limit_now, 65536);
		expected_results.push_back(pr.res);
		points_to_send.push_back(pt);
	endtask

	task automatic drain();
		while (points_to_send.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] lim, input int n_items, input int idle);
		mbe_pkg::point_t    pt;
		escape_prediction_t pr;
		int                 tries;
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_now = lim;
		sender_idle_pct = idle;
		@(negedge clk);
		for (int i = 0; i < n_items; i++) begin
			pr.rounds = ROUND_CAP + 1;
			tries = 0;
			while (pr.rounds > ROUND_CAP && tries < 20) begin
				pt = random_point();
				pr = escape_time_of(pt, lim, ROUND_CAP);
				tries++;
			end
			// A point far outside escapes at once.
			if (pr.rounds > ROUND_CAP) begin
				pt.point_real = 32'h4000_0000;
				pt.point_imag = $urandom;
			end
			queue_point(pt.point_real, pt.point_imag);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Request driver: offers the next queued point unless it chooses to idle this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			point_in <= '0;
		end else if (!start || !busy) begin
			if (points_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				start <= 1'b1;
				point_in <= points_to_send.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		mbe_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("result with no request outstanding: inside=%0d count=%0d mag=%h",
						result.inside_res, result.escape_count, result.final_magnitude_sq);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (result.inside_res !== want.inside_res
						|| result.escape_count !== want.escape_count
						|| result.final_magnitude_sq !== want.final_magnitude_sq) begin
					if (mismatches < 10)
						$display("mismatch: expected inside=%0d count=%0d mag=%h, got inside=%0d count=%0d mag=%h",
							want.inside_res, want.escape_count, want.final_magnitude_sq,
							result.inside_res, result.escape_count, result.final_magnitude_sq);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[mandelbrot_escape_iteration_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed points under the reset limit of 256.
		queue_point(32'h0000_0000, 32'h0000_0000);   // cardioid center
		queue_point(32'hF000_0000, 32'h0000_0000);   // period-2 bulb center
		queue_point(32'h0400_0000, 32'h0000_0000);   // cardioid cusp, runs to the limit
		queue_point(32'hE000_0000, 32'h0000_0000);   // -2, escapes right away
		queue_point(32'h0000_0000, 32'h1000_0000);   // i, bounded outside both tests
		queue_point(32'hF400_0000, 32'h0199_999A);   // near the neck, slow escape
		queue_point(32'h04CC_CCCD, 32'h0000_0000);   // just past the cusp
		queue_point(32'hF000_0000, 32'h0400_0000);   // on the bulb edge
		queue_point(32'h8000_0000, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000);
		queue_point(32'h8000_0000, 32'h0000_0000);
		queue_point(32'h0000_0000, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h0000_0000);
		queue_point(32'h0000_0000, 32'h7FFF_FFFF);
		queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_point(32'h0000_0001, 32'h0000_0001);
		queue_point(32'h5555_5555, 32'hAAAA_AAAA);
		queue_point(32'hAAAA_AAAA, 32'h5555_5555);

		run_phase(16'd256, 100, 11);
		run_phase(16'd1, 40, 11);
		run_phase(16'd65535, 80, 11);
		run_phase(16'd0, 30, 53);
		run_phase(16'd2, 60, 53);
		// The same limit twice; the sender drains every result in between, as before each phase.
		run_phase(16'd20, 60, 53);
		run_phase(16'd20, 60, 53);
		run_phase(16'd7, 100, 0);
		run_phase(16'd64, 120, 0);
		drain();

		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("[mandelbrot_escape_iteration_unit] OK");
		else
			$display("[mandelbrot_escape_iteration_unit] ERROR");
		$finish;
	end

endmodule
